### rtl/one_wire_rom_search_core_macros.svh
// Assertion macros shared by the ROM search core modules
`ifndef ONE_WIRE_ROM_SEARCH_CORE_MACROS_SVH
`define ONE_WIRE_ROM_SEARCH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OWRS_ASSERT(lbl, clk_i, rst_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (prop)) \
    else $error("owrs assertion failed");
`define OWRS_ASSERT_IMP(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("owrs assertion failed");
`else
`define OWRS_ASSERT(lbl, clk_i, rst_i, prop)
`define OWRS_ASSERT_IMP(lbl, clk_i, rst_i, ante, cons)
`endif
`endif

### rtl/owrs_pkg.sv
// Types and constants of the 1-Wire ROM search core
package owrs_pkg;

  localparam logic [6:0] ROM_BITS     = 7'd64;
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;
  localparam int         FAMILY_BITS  = 8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_BEGIN    = 2'd1;
  localparam logic [1:0] CMD_BIT_PAIR = 2'd2;

  localparam logic [2:0] KIND_SEND    = 3'd0;
  localparam logic [2:0] KIND_DIR     = 3'd1;
  localparam logic [2:0] KIND_FOUND   = 3'd2;
  localparam logic [2:0] KIND_FAIL    = 3'd3;
  localparam logic [2:0] KIND_CLEARED = 3'd4;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  send_byte;
    logic        direction;
    logic [63:0] rom_code;
    logic        last_device;
    logic [3:0]  family_branch;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

### rtl/owrs_engine.sv
// Input register, search state and per-item decision logic
`include "one_wire_rom_search_core_macros.svh"
module owrs_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic                presence,
  input  logic                id_bit,
  input  logic                complement_bit,
  input  logic [7:0]          search_command,
  input  logic                room,
  output owrs_pkg::push_t     push
);

  logic        hold_valid;
  logic [1:0]  hold_cmd;
  logic        hold_pres;
  logic        hold_id;
  logic        hold_cmp;
  logic        fire;

  logic [63:0] rom_bits, rom_bits_next;
  logic [6:0]  last_branch, last_branch_next;
  logic [3:0]  family_branch_pos, family_branch_pos_next;
  logic        done_flag, done_flag_next;
  logic [6:0]  bit_position, bit_position_next;
  logic [6:0]  zero_branch, zero_branch_next;
  logic        searching, searching_next;

  logic [6:0]  pos;
  logic [5:0]  sh;
  logic        dir;

  assign fire     = hold_valid && room;
  assign in_stall = hold_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      hold_cmd  <= command;
      hold_pres <= presence;
      hold_id   <= id_bit;
      hold_cmp  <= complement_bit;
    end
  end

  always_comb begin
    rom_bits_next          = rom_bits;
    last_branch_next       = last_branch;
    family_branch_pos_next = family_branch_pos;
    done_flag_next         = done_flag;
    bit_position_next      = bit_position;
    zero_branch_next       = zero_branch;
    searching_next         = searching;
    push                   = '0;
    dir                    = 1'b0;
    pos = ((bit_position == 7'd0) || (bit_position > owrs_pkg::ROM_BITS)) ?
          7'd1 : bit_position;
    sh  = 6'(pos - 7'd1);
    unique case (hold_cmd)
      owrs_pkg::CMD_CLEAR: begin
        rom_bits_next                 = '0;
        last_branch_next              = '0;
        family_branch_pos_next        = '0;
        done_flag_next                = 1'b0;
        bit_position_next             = 7'd1;
        zero_branch_next              = '0;
        searching_next                = 1'b0;
        push.count                    = 2'd1;
        push.first.result_kind        = owrs_pkg::KIND_CLEARED;
        push.first.last_of_run        = 1'b1;
      end
      owrs_pkg::CMD_BEGIN: begin
        push.count             = 2'd1;
        push.first.last_of_run = 1'b1;
        if (done_flag || !hold_pres) begin
          last_branch_next       = '0;
          family_branch_pos_next = '0;
          done_flag_next         = 1'b0;
          searching_next         = 1'b0;
          push.first.result_kind = owrs_pkg::KIND_FAIL;
        end else begin
          searching_next         = 1'b1;
          bit_position_next      = 7'd1;
          zero_branch_next       = '0;
          push.first.result_kind = owrs_pkg::KIND_SEND;
          push.first.send_byte   = search_command;
        end
      end
      owrs_pkg::CMD_BIT_PAIR: begin
        if (searching) begin
          if (hold_id && hold_cmp) begin
            last_branch_next       = '0;
            family_branch_pos_next = '0;
            done_flag_next         = 1'b0;
            searching_next         = 1'b0;
            push.count             = 2'd1;
            push.first.result_kind = owrs_pkg::KIND_FAIL;
            push.first.last_of_run = 1'b1;
          end else begin
            if (hold_id != hold_cmp) begin
              dir = hold_id;
            end else begin
              if (pos < last_branch) begin
                dir = rom_bits[sh];
              end else begin
                dir = (pos == last_branch);
              end
              if (!dir) begin
                zero_branch_next = pos;
                if (pos < owrs_pkg::FAMILY_LIMIT) begin
                  family_branch_pos_next = pos[3:0];
                end
              end
            end
            rom_bits_next[sh]      = dir;
            push.first.result_kind = owrs_pkg::KIND_DIR;
            push.first.direction   = dir;
            if (pos < owrs_pkg::ROM_BITS) begin
              bit_position_next      = pos + 7'd1;
              push.count             = 2'd1;
              push.first.last_of_run = 1'b1;
            end else begin
              bit_position_next       = 7'd1;
              searching_next          = 1'b0;
              last_branch_next        = zero_branch_next;
              done_flag_next          = (zero_branch_next == 7'd0);
              push.count              = 2'd2;
              push.second.last_of_run = 1'b1;
              if (rom_bits_next[owrs_pkg::FAMILY_BITS-1:0] == '0) begin
                last_branch_next        = '0;
                family_branch_pos_next  = '0;
                done_flag_next          = 1'b0;
                push.second.result_kind = owrs_pkg::KIND_FAIL;
              end else begin
                push.second.result_kind   = owrs_pkg::KIND_FOUND;
                push.second.rom_code      = rom_bits_next;
                push.second.last_device   = done_flag_next;
                push.second.family_branch = family_branch_pos_next;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bits          <= '0;
      last_branch       <= '0;
      family_branch_pos <= '0;
      done_flag         <= 1'b0;
      bit_position      <= 7'd1;
      zero_branch       <= '0;
      searching         <= 1'b0;
    end else if (fire) begin
      rom_bits          <= rom_bits_next;
      last_branch       <= last_branch_next;
      family_branch_pos <= family_branch_pos_next;
      done_flag         <= done_flag_next;
      bit_position      <= bit_position_next;
      zero_branch       <= zero_branch_next;
      searching         <= searching_next;
    end
  end

  `OWRS_ASSERT(a_pos_range, clk, rst, (bit_position >= 7'd1) && (bit_position <= owrs_pkg::ROM_BITS))
  `OWRS_ASSERT_IMP(a_done_idle, clk, rst, done_flag, !searching)
  `OWRS_ASSERT_IMP(a_pair_end, clk, rst, push.count == 2'd2, fire && (hold_cmd == owrs_pkg::CMD_BIT_PAIR) && (bit_position == owrs_pkg::ROM_BITS))

endmodule

### rtl/owrs_resq.sv
// Result queue taking up to two beats per cycle and giving one unless out_stall is high
`include "one_wire_rom_search_core_macros.svh"
module owrs_resq (
  input  logic                clk,
  input  logic                rst,
  input  owrs_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output owrs_pkg::res_t      head
);

  owrs_pkg::res_t                  mem [owrs_pkg::QDEPTH];
  logic [owrs_pkg::QPTR_W-1:0]     wr_ptr;
  logic [owrs_pkg::QPTR_W-1:0]     rd_ptr;
  logic [owrs_pkg::QCNT_W-1:0]     count;
  logic                            pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= owrs_pkg::QCNT_W'(owrs_pkg::QDEPTH - 2));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + owrs_pkg::QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + owrs_pkg::QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + owrs_pkg::QPTR_W'(1);
      end
      count <= count + owrs_pkg::QCNT_W'(push.count) - owrs_pkg::QCNT_W'(pop);
    end
  end

  `OWRS_ASSERT_IMP(a_no_overfill, clk, rst, push.count != 2'd0, room)
  `OWRS_ASSERT(a_count_max, clk, rst, count <= owrs_pkg::QCNT_W'(owrs_pkg::QDEPTH))

endmodule

### rtl/one_wire_rom_search_core.sv
// Top level of the 1-Wire ROM search core: search command register and result port
// The core takes one item per clock on the input channel unless stalled and answers
// with result beats via the input register, which updates the search state, and the
// four-entry result queue. Clear and begin items give one beat, a bit pair one only
// while searching; the bit pair ending a pass gives two (direction, then found or failed),
// so sustained throughput is one beat per cycle unless out_stall is high, set by the
// queue's single read port. Users write the search command byte on the always-ready
// configuration channel only while no item is in flight; the core does not check this.
module one_wire_rom_search_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  search_command,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic        presence,
  input  logic        id_bit,
  input  logic        complement_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [7:0]  send_byte,
  output logic        direction,
  output logic [63:0] rom_code,
  output logic        last_device,
  output logic [3:0]  family_branch,
  output logic        last_of_run
);

  logic [7:0]      cmd_byte;
  logic            room;
  owrs_pkg::push_t push;
  owrs_pkg::res_t  head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_byte <= 8'hF0;
    end else if (cfg_valid && cfg_ready) begin
      cmd_byte <= search_command;
    end
  end

  owrs_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .presence       (presence),
    .id_bit         (id_bit),
    .complement_bit (complement_bit),
    .search_command (cmd_byte),
    .room           (room),
    .push           (push)
  );

  owrs_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign result_kind   = head.result_kind;
  assign send_byte     = head.send_byte;
  assign direction     = head.direction;
  assign rom_code      = head.rom_code;
  assign last_device   = head.last_device;
  assign family_branch = head.family_branch;
  assign last_of_run   = head.last_of_run;

endmodule
